/* sv/bounded_array_list_macros.svh */
// Assertion macros shared by the bounded array list RTL.
// Depends on i_clk and i_rst_n being visible in the module that uses them.
`ifndef BOUNDED_ARRAY_LIST_MACROS_SVH
`define BOUNDED_ARRAY_LIST_MACROS_SVH

// same-cycle implication
`define BAL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BAL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bal_pkg.sv */
// Types and constants for the bounded array list.
// No dependencies; imported by bal_seq and bounded_array_list.
`default_nettype none

package bal_pkg;

    localparam int OP_W      = 3;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 4;
    localparam int ERR_W     = 2;
    localparam int CNT_OUT_W = 4;

    localparam logic [OP_W-1:0] OP_INS_AT    = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_AT    = 3'd3;
    localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd4;
    localparam logic [OP_W-1:0] OP_REM_BACK  = 3'd5;
    localparam logic [OP_W-1:0] OP_SEARCH    = 3'd6;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_PUT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        K_NONE,
        K_INS,
        K_REM,
        K_SRCH
    } t_kind;

    typedef struct packed {
        logic [VAL_W-1:0]     removed_value;
        logic                 found;
        logic [ERR_W-1:0]     error_code;
        logic [CNT_OUT_W-1:0] count_now;
    } t_result;

endpackage

`default_nettype wire

/* sv/bounded_array_list.sv */
// Bounded array list: an ordered list of up to DEPTH 32-bit elements packed
// from position 0. Each transaction inserts (at a position, front or back),
// removes (at a position, front or back) or searches, and yields one result.
// Elements live in a single-port-write, single-port-read memory with registered
// read data; a shift or a scan reads one entry per cycle, a shift writes it back
// one place over and a scan compares it. The walk covers the entries behind the
// insert point, those from the remove point to the end, or all entries for
// search, and then drains the read pipeline; an insert then writes the new
// element. An insert with nothing to shift goes straight to that write, and a
// failed operation, an unused op code or a search of an empty list goes
// straight to the result. The input stall drops in the cycle after the result
// moves into the output register.
// Errors (full, empty, position out of range) change nothing. A new
// transaction is taken while the previous result waits in the output register.
// Uses bal_pkg, bal_seq and bal_mem.
`default_nettype none

module bounded_array_list
    import bal_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [OP_W-1:0]      i_op,
    input  wire logic [VAL_W-1:0]     i_item_value,
    input  wire logic [POS_W-1:0]     i_position,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic      [VAL_W-1:0]     o_removed_value,
    output logic                      o_found,
    output logic      [ERR_W-1:0]     o_error_code,
    output logic      [CNT_OUT_W-1:0] o_count_now
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic             busy;
    logic             res_valid;
    logic             res_ready;
    t_result          res;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [VAL_W-1:0] mem_rdata;

    logic             r_out_valid;
    t_result          r_out;

    bal_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (VAL_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bal_seq #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_op         (i_op),
        .i_item_value (i_item_value),
        .i_position   (i_position),
        .o_busy       (busy),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    assign o_in_stall = busy;

    // output register frees when empty or when its transaction is taken
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
            if (res_valid) begin
                r_out <= res;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_removed_value = r_out.removed_value;
    assign o_found         = r_out.found;
    assign o_error_code    = r_out.error_code;
    assign o_count_now     = r_out.count_now;

endmodule

`default_nettype wire

/* sv/bal_mem.sv */
// Element storage: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module bal_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/bal_seq.sv */
// Operation sequencer: decodes a transaction, walks the element memory
// (shift up, shift down, or scan) and builds the result. Uses bal_pkg.
`default_nettype none
`include "bounded_array_list_macros.svh"

module bal_seq
    import bal_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int CW    = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [VAL_W-1:0]  i_item_value,
    input  wire logic [POS_W-1:0]  i_position,
    output logic                   o_busy,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output t_result                o_res,
    output logic                   o_mem_we,
    output logic      [AW-1:0]     o_mem_waddr,
    output logic      [VAL_W-1:0]  o_mem_wdata,
    output logic      [AW-1:0]     o_mem_raddr,
    input  wire logic [VAL_W-1:0]  i_mem_rdata
);

    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    t_state              r_state, n_state;
    t_kind               r_kind;
    logic [CW-1:0]       r_count;
    logic [VAL_W-1:0]    r_val;
    logic [AW-1:0]       r_at;
    logic [AW-1:0]       r_rd;
    logic [AW-1:0]       r_last;
    logic                r_active;
    logic                r_pend;
    logic [AW-1:0]       r_pend_addr;
    logic [VAL_W-1:0]    r_removed;
    logic                r_found;
    logic [ERR_W-1:0]    r_err;

    // decode results
    t_kind               d_kind;
    logic [ERR_W-1:0]    d_err;
    logic [XW-1:0]       d_at_x;
    logic [AW-1:0]       d_rd;
    logic [AW-1:0]       d_last;
    logic                d_active;
    logic [CW-1:0]       d_count;

    logic                accept;
    logic [XW-1:0]       cnt_x;
    logic [XW-1:0]       pos_x;
    logic [AW-1:0]       cnt_m1;

    assign accept = (r_state == S_IDLE) && i_valid;
    assign cnt_x  = XW'(r_count);
    assign pos_x  = XW'(i_position);
    assign cnt_m1 = AW'(r_count - CW'(1));

    always_comb begin
        d_kind   = K_NONE;
        d_err    = ERR_OK;
        d_at_x   = '0;
        d_rd     = '0;
        d_last   = '0;
        d_active = 1'b0;
        d_count  = r_count;
        unique case (i_op) inside
            OP_INS_AT, OP_INS_FRONT, OP_INS_BACK: begin
                d_kind = K_INS;
                if (i_op == OP_INS_AT) begin
                    d_at_x = pos_x;
                end else if (i_op == OP_INS_BACK) begin
                    d_at_x = cnt_x;
                end
                if (r_count == DEPTH_C) begin
                    d_err = ERR_FULL;
                end else if (d_at_x > cnt_x) begin
                    d_err = ERR_RANGE;
                end else begin
                    // walk from the last entry down to the insert point
                    d_rd     = cnt_m1;
                    d_last   = AW'(d_at_x);
                    d_active = (d_at_x != cnt_x);
                    d_count  = r_count + CW'(1);
                end
            end
            OP_REM_AT, OP_REM_FRONT, OP_REM_BACK: begin
                d_kind = K_REM;
                if (i_op == OP_REM_AT) begin
                    d_at_x = pos_x;
                end else if (i_op == OP_REM_BACK) begin
                    d_at_x = XW'(cnt_m1);
                end
                if (r_count == '0) begin
                    d_err = ERR_EMPTY;
                end else if (d_at_x >= cnt_x) begin
                    d_err = ERR_RANGE;
                end else begin
                    // first read is the removed entry, the rest move down
                    d_rd     = AW'(d_at_x);
                    d_last   = cnt_m1;
                    d_active = 1'b1;
                    d_count  = r_count - CW'(1);
                end
            end
            OP_SEARCH: begin
                d_kind   = K_SRCH;
                d_rd     = '0;
                d_last   = cnt_m1;
                d_active = (r_count != '0);
            end
            default: begin
                d_kind = K_NONE;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (d_err != ERR_OK) begin
                        n_state = S_DONE;
                    end else if (d_active) begin
                        n_state = S_WALK;
                    end else if (d_kind == K_INS) begin
                        n_state = S_PUT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_WALK: begin
                if (!r_active && !r_pend) begin
                    n_state = (r_kind == K_INS) ? S_PUT : S_DONE;
                end
            end
            S_PUT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_busy      = (r_state != S_IDLE);
        o_res_valid = (r_state == S_DONE);
        o_mem_we    = 1'b0;
        o_mem_waddr = r_at;
        o_mem_wdata = i_mem_rdata;
        unique case (r_state)
            S_WALK: begin
                if (r_pend && r_kind == K_INS) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_pend_addr + AW'(1);
                end else if (r_pend && r_kind == K_REM && r_pend_addr != r_at) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_pend_addr - AW'(1);
                end
            end
            S_PUT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_at;
                o_mem_wdata = r_val;
            end
            default: begin
                o_mem_we = 1'b0;
            end
        endcase
    end

    assign o_mem_raddr = r_rd;

    assign o_res.removed_value = r_removed;
    assign o_res.found         = r_found;
    assign o_res.error_code    = r_err;
    assign o_res.count_now     = CNT_OUT_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_active <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_kind    <= d_kind;
                r_val     <= i_item_value;
                r_at      <= AW'(d_at_x);
                r_rd      <= d_rd;
                r_last    <= d_last;
                r_active  <= d_active && (d_err == ERR_OK);
                r_pend    <= 1'b0;
                r_removed <= '0;
                r_found   <= 1'b0;
                r_err     <= d_err;
                r_count   <= d_count;
            end else if (r_state == S_WALK) begin
                r_pend      <= r_active;
                r_pend_addr <= r_rd;
                if (r_active) begin
                    if (r_rd == r_last) begin
                        r_active <= 1'b0;
                    end else if (r_kind == K_INS) begin
                        r_rd <= r_rd - AW'(1);
                    end else begin
                        r_rd <= r_rd + AW'(1);
                    end
                end
                if (r_pend) begin
                    if (r_kind == K_REM && r_pend_addr == r_at) begin
                        r_removed <= i_mem_rdata;
                    end
                    if (r_kind == K_SRCH && i_mem_rdata == r_val) begin
                        r_found <= 1'b1;
                    end
                end
            end
        end
    end

    `BAL_ASSERT_NOW(a_count_bound, 1'b1, r_count <= DEPTH_C, "count above capacity")
    `BAL_ASSERT_NOW(a_write_state, o_mem_we, (r_state == S_WALK) || (r_state == S_PUT), "write outside walk")
    `BAL_ASSERT_NEXT(a_accept_busy, accept, r_state != S_IDLE, "accepted transaction dropped")
    `BAL_ASSERT_NOW(a_err_clean, (r_state == S_DONE) && (r_err != ERR_OK), (r_removed == '0) && !r_found, "error result carries data")

endmodule

`default_nettype wire

/* bench/bal_checker.sv */
`timescale 1ns / 1ps
// Checker for the bounded array list: watches both channels, keeps its own copy
// of the list, predicts each result and compares it field by field.
// Depends on bal_pkg for field widths, op codes, error codes and t_result.

module bal_checker
    import bal_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire logic [OP_W-1:0]      i_op,
    input  wire logic [VAL_W-1:0]     i_item_value,
    input  wire logic [POS_W-1:0]     i_position,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic [VAL_W-1:0]     i_removed_value,
    input  wire logic                 i_found,
    input  wire logic [ERR_W-1:0]     i_error_code,
    input  wire logic [CNT_OUT_W-1:0] i_count_now,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked
);

    logic [VAL_W-1:0] list_store [DEPTH];
    int               list_len;
    t_result          awaited_results [$];
    int               fails;
    int               checked;

    // Applies one list operation to the local copy and returns its result.
    function automatic t_result apply_list_op(input logic [OP_W-1:0]  op_code,
                                              input logic [VAL_W-1:0] value,
                                              input logic [POS_W-1:0] pos);
        t_result r;
        int      at;
        int      k;
        r = '0;
        case (op_code)
            OP_INS_AT, OP_INS_FRONT, OP_INS_BACK: begin
                if (list_len >= DEPTH) begin
                    r.error_code = ERR_FULL;
                end else begin
                    at = (op_code == OP_INS_AT) ? int'(pos) :
                         (op_code == OP_INS_FRONT) ? 0 : list_len;
                    if (at > list_len) begin
                        r.error_code = ERR_RANGE;
                    end else begin
                        for (k = list_len; k > at; k--)
                            list_store[k] = list_store[k-1];
                        list_store[at] = value;
                        list_len++;
                    end
                end
            end
            OP_REM_AT, OP_REM_FRONT, OP_REM_BACK: begin
                if (list_len == 0) begin
                    r.error_code = ERR_EMPTY;
                end else begin
                    at = (op_code == OP_REM_AT) ? int'(pos) :
                         (op_code == OP_REM_FRONT) ? 0 : list_len - 1;
                    if (at >= list_len) begin
                        r.error_code = ERR_RANGE;
                    end else begin
                        r.removed_value = list_store[at];
                        list_len--;
                        for (k = at; k < list_len; k++)
                            list_store[k] = list_store[k+1];
                    end
                end
            end
            OP_SEARCH: begin
                for (k = 0; k < list_len; k++)
                    if (list_store[k] == value)
                        r.found = 1'b1;
            end
            default: ;
        endcase
        r.count_now = CNT_OUT_W'(list_len);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            awaited_results.delete();
            list_len = 0;
            fails    = 0;
            checked  = 0;
        end else begin
            // results first: a result leaving on this edge never belongs to
            // a transaction accepted on the same edge
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("[%0t] unexpected result: removed=%h found=%b err=%0d count=%0d",
                                 $time, i_removed_value, i_found, i_error_code, i_count_now);
                end else begin
                    want = awaited_results.pop_front();
                    checked++;
                    if (i_removed_value !== want.removed_value || i_found !== want.found ||
                        i_error_code !== want.error_code || i_count_now !== want.count_now) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("[%0t] mismatch: want removed=%h found=%b err=%0d count=%0d",
                                     $time, want.removed_value, want.found, want.error_code,
                                     want.count_now);
                            $display("[%0t] mismatch: got  removed=%h found=%b err=%0d count=%0d",
                                     $time, i_removed_value, i_found, i_error_code,
                                     i_count_now);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_results.push_back(apply_list_op(i_op, i_item_value, i_position));
        end
        o_fail_count <= fails;
        o_pending    <= awaited_results.size();
        o_checked    <= checked;
    end

endmodule

/* bench/tb_bounded_array_list.sv */
`timescale 1ns / 1ps
// Top of the bounded array list testbench: clock, reset, stimulus and verdict.
// Depends on bal_pkg, bounded_array_list and bal_checker.

module tb_bounded_array_list
    import bal_pkg::*;
();

    localparam int DEPTH          = 8;
    localparam int RANDOM_ITEMS   = 1330;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DRAIN_CYCLES   = 4 * (DEPTH + 4);

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_stall;
    logic [OP_W-1:0]      in_op         = OP_SEARCH;
    logic [VAL_W-1:0]     in_item_value = '0;
    logic [POS_W-1:0]     in_position   = '0;
    logic                 out_valid;
    logic                 out_stall     = 1'b0;
    logic [VAL_W-1:0]     removed_value;
    logic                 found;
    logic [ERR_W-1:0]     error_code;
    logic [CNT_OUT_W-1:0] count_now;

    int chk_fails;
    int chk_pending;
    int chk_checked;
    int cycle_count = 0;
    int n_ins = 0, n_rem = 0, n_srch = 0, n_other = 0;

    logic [VAL_W-1:0] recent_values [8];
    int               recent_wr = 0;

    always #5 clk = ~clk;

    bounded_array_list #(.DEPTH(DEPTH)) DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_op            (in_op),
        .i_item_value    (in_item_value),
        .i_position      (in_position),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_removed_value (removed_value),
        .o_found         (found),
        .o_error_code    (error_code),
        .o_count_now     (count_now)
    );

    bal_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_op            (in_op),
        .i_item_value    (in_item_value),
        .i_position      (in_position),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_removed_value (removed_value),
        .i_found         (found),
        .i_error_code    (error_code),
        .i_count_now     (count_now),
        .o_fail_count    (chk_fails),
        .o_pending       (chk_pending),
        .o_checked       (chk_checked)
    );

    // receiver back-pressure: free flow, light, heavy and periodic stretches
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        case ((cycle_count / 300) % 4)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 30);
            2:       out_stall <= ($urandom_range(0, 99) < 70);
            default: out_stall <= ((cycle_count % 7) >= 4);
        endcase
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, chk_pending);
            $display("simulation failed");
            $finish;
        end
    end

    // Presents one transaction and holds it until accepted.
    task automatic send_op(input logic [OP_W-1:0]  op_code,
                           input logic [VAL_W-1:0] value,
                           input logic [POS_W-1:0] pos);
        in_valid      <= 1'b1;
        in_op         <= op_code;
        in_item_value <= value;
        in_position   <= pos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        case (op_code)
            OP_INS_AT, OP_INS_FRONT, OP_INS_BACK: begin
                n_ins++;
                recent_values[recent_wr] = value;
                recent_wr = (recent_wr + 1) % 8;
            end
            OP_REM_AT, OP_REM_FRONT, OP_REM_BACK: n_rem++;
            OP_SEARCH:                            n_srch++;
            default:                              n_other++;
        endcase
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [OP_W-1:0] pick_op(input int mix);
        int ins_pct;
        int rem_pct;
        int r;
        int k;
        ins_pct = (mix == 0) ? 65 : (mix == 1) ? 20 : 40;
        rem_pct = (mix == 0) ? 20 : (mix == 1) ? 62 : 40;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 2);
        if (r < ins_pct)
            return (k == 0) ? OP_INS_AT : (k == 1) ? OP_INS_FRONT : OP_INS_BACK;
        if (r < ins_pct + rem_pct)
            return (k == 0) ? OP_REM_AT : (k == 1) ? OP_REM_FRONT : OP_REM_BACK;
        if (r < 98)
            return OP_SEARCH;
        return OP_UNUSED;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return recent_values[$urandom_range(0, 7)];
        if (r < 40)
            return '0;
        if (r < 45)
            return '1;
        return $urandom;
    endfunction

    initial begin
        int sent;
        int burst;
        int gap;
        int mix;
        int next_sync;

        for (int k = 0; k < 8; k++)
            recent_values[k] = $urandom;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every remove reports empty, search finds nothing
        send_op(OP_REM_FRONT, 32'h0, 4'd0);
        send_op(OP_REM_BACK,  32'h0, 4'd0);
        send_op(OP_REM_AT,    32'h0, 4'd15);
        send_op(OP_SEARCH,    32'h0, 4'd0);
        send_op(OP_INS_AT,    32'h1111_1111, 4'd1);
        // fill to capacity from every side
        send_op(OP_INS_AT,    32'hFFFF_FFFF, 4'd0);
        send_op(OP_INS_FRONT, 32'h0000_0000, 4'd0);
        send_op(OP_INS_BACK,  32'hA5A5_A5A5, 4'd0);
        send_op(OP_INS_AT,    32'h5A5A_5A5A, 4'd1);
        send_op(OP_INS_AT,    32'h2222_2222, 4'd15);
        send_op(OP_INS_AT,    32'h3333_3333, 4'd4);
        send_op(OP_INS_BACK,  32'h8000_0001, 4'd0);
        send_op(OP_INS_FRONT, 32'h7FFF_FFFE, 4'd0);
        send_op(OP_INS_BACK,  32'hDEAD_BEEF, 4'd0);
        // full list: fullness wins over a bad position
        send_op(OP_INS_AT,    32'h4444_4444, 4'd9);
        send_op(OP_INS_FRONT, 32'h4444_4444, 4'd0);
        send_op(OP_SEARCH,    32'hFFFF_FFFF, 4'd0);
        send_op(OP_SEARCH,    32'h1234_5678, 4'd0);
        send_op(OP_UNUSED,    32'hFFFF_FFFF, 4'd15);
        send_op(OP_REM_AT,    32'h0, 4'd8);
        send_op(OP_REM_AT,    32'h0, 4'd7);
        send_op(OP_REM_AT,    32'h0, 4'd0);
        send_op(OP_REM_FRONT, 32'h0, 4'd0);
        send_op(OP_REM_BACK,  32'h0, 4'd0);
        send_op(OP_REM_AT,    32'h0, 4'd2);
        pause_until_drained();

        sent      = 0;
        next_sync = 337;
        while (sent < RANDOM_ITEMS) begin
            mix   = (sent / 90) % 3;
            burst = $urandom_range(1, 16);
            for (int b = 0; b < burst; b++) begin
                send_op(pick_op(mix), pick_value(),
                        ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 9))
                                                     : 4'($urandom_range(0, 15)));
                sent++;
            end
            if (sent >= next_sync) begin
                pause_until_drained();
                next_sync += 337;
            end else if ((sent / 200) % 2 == 1 || $urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 8);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d transactions: %0d inserts, %0d removes, %0d searches, %0d unused op",
                 n_ins + n_rem + n_srch + n_other, n_ins, n_rem, n_srch, n_other);
        $display("compared %0d results, %0d mismatches", chk_checked, chk_fails);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
